// ===== rtl/linear_priority_scheduler_macros.svh =====
// Assertion macros for the linear priority scheduler.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef LINEAR_PRIORITY_SCHEDULER_MACROS_SVH
`define LINEAR_PRIORITY_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LPS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LPS_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LPS_ASSERT(lbl, clk, rst, prop, msg)
`define LPS_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/lps_pkg.sv =====
// Shared types, widths and codes of the linear priority scheduler.
// No dependencies; imported by lps_if, lps_cmp, the scheduler and the testbench.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int MODE_W    = 2;
  localparam int ID_W      = 16;
  localparam int PRIO_W    = 16;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 7;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SERVE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_SERVED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic better;
    logic id_match;
  } cmp_res_t;

endpackage

// ===== rtl/lps_if.sv =====
// Valid/ready channel interfaces for command and response words.
// Depends on lps_pkg for field widths.
`timescale 1ns / 1ps

interface lps_cmd_if import lps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, mode, task_id, priority_req, input ready);
  modport sink (input valid, mode, task_id, priority_req, output ready);
endinterface

interface lps_rsp_if import lps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   served_id;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  remaining;

  modport source (output valid, status, served_id, position, remaining, input ready);
  modport sink (input valid, status, served_id, position, remaining, output ready);
endinterface

// ===== rtl/lps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lps_cmp.sv =====
// Shared entry comparator: priority order with lowest-id tie break, and id match.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_cmp import lps_pkg::*; (
  input  entry_t          cand,
  input  entry_t          best,
  input  logic [ID_W-1:0] key_id,
  output cmp_res_t        res
);

  always_comb begin
    res.better   = (cand.prio > best.prio) ||
                   ((cand.prio == best.prio) && (cand.id < best.id));
    res.id_match = (cand.id == key_id);
  end

endmodule

// ===== rtl/linear_priority_scheduler.sv =====
// Takes one command at a time: an add writes the new entry, a full add or an empty
// serve goes straight to the response word, an update scans the table for the id,
// and a serve scans for the best entry, shifts the entries behind it down and loads
// the response word, which waits while the previous word is still held.
// All table traffic goes through one RAM port pair and one shared comparator.
// Reset clears the entry count, the sequencer and the response valid, not the table RAM.
`timescale 1ns / 1ps

module linear_priority_scheduler import lps_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input logic       clk,
  input logic       rst,
  lps_cmd_if.sink   cmd,
  lps_rsp_if.source rsp
);

`include "linear_priority_scheduler_macros.svh"

  typedef enum logic [2:0] {ST_IDLE, ST_UPD, ST_SCAN, ST_SHIFT, ST_EMIT} state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd_ptr;
  logic               rd_vld;
  logic [AW-1:0]      cmp_idx;
  logic [ID_W-1:0]    key_id;
  logic [PRIO_W-1:0]  key_prio;
  entry_t             best;
  logic [AW-1:0]      best_idx;
  logic [STAT_W-1:0]  res_status;
  logic [ID_W-1:0]    res_id;
  logic [POS_W-1:0]   res_pos;
  logic [POS_W-1:0]   res_rem;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [ID_W-1:0]    out_id;
  logic [POS_W-1:0]   out_pos;
  logic [POS_W-1:0]   out_rem;

  logic               accept;
  logic               full;
  logic               add_ok;
  logic               issue;
  logic               upd_hit;
  logic               scan_done;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  cmp_res_t           cmp;

  assign cmd.ready     = (state == ST_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.served_id = out_id;
  assign rsp.position  = out_pos;
  assign rsp.remaining = out_rem;

  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign add_ok    = accept && (cmd.mode == MODE_ADD) && !full;
  assign issue     = ((state == ST_UPD) || (state == ST_SCAN) || (state == ST_SHIFT)) &&
                     (rd_ptr < count);
  assign upd_hit   = (state == ST_UPD) && rd_vld && cmp.id_match;
  assign scan_done = !issue && !rd_vld;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = '{id: cmd.task_id, prio: cmd.priority_req};
    if (add_ok) begin
      ram_we = 1'b1;
    end else if (upd_hit) begin
      ram_we    = 1'b1;
      ram_waddr = cmp_idx;
      ram_wdata = '{id: ram_rdata.id, prio: key_prio};
    end else if ((state == ST_SHIFT) && rd_vld) begin
      ram_we    = 1'b1;
      ram_waddr = cmp_idx - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  lps_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(ram_rdata)
  );

  lps_cmp u_cmp (
    .cand  (ram_rdata),
    .best  (best),
    .key_id(key_id),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      rd_vld <= issue;
      if (issue) begin
        rd_ptr  <= rd_ptr + CNT_W'(1);
        cmp_idx <= rd_ptr[AW-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            key_id   <= cmd.task_id;
            key_prio <= cmd.priority_req;
            rd_ptr   <= '0;
            case (cmd.mode)
              MODE_ADD: begin
                if (full) begin
                  res_status <= STAT_FULL;
                  res_id     <= '0;
                  res_pos    <= '0;
                  res_rem    <= POS_W'(count);
                  state      <= ST_EMIT;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              MODE_UPDATE: begin
                state <= ST_UPD;
              end
              MODE_SERVE: begin
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                  res_id     <= '0;
                  res_pos    <= '0;
                  res_rem    <= '0;
                  state      <= ST_EMIT;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_UPD: begin
          if (upd_hit || scan_done) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (rd_vld && ((cmp_idx == '0) || cmp.better)) begin
            best     <= ram_rdata;
            best_idx <= cmp_idx;
          end
          if (scan_done) begin
            rd_ptr <= CNT_W'(best_idx) + CNT_W'(1);
            state  <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (scan_done) begin
            count      <= count - CNT_W'(1);
            res_status <= STAT_SERVED;
            res_id     <= best.id;
            res_pos    <= POS_W'(CNT_W'(best_idx) + CNT_W'(1));
            res_rem    <= POS_W'(count - CNT_W'(1));
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_id     <= res_id;
            out_pos    <= res_pos;
            out_rem    <= res_rem;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LPS_NEVER(a_count_bound, clk, rst, count > CNT_W'(DEPTH), "entry count above depth")
  `LPS_ASSERT(a_empty_serve, clk, rst, accept && (cmd.mode == MODE_SERVE) && (count == '0) |=> state == ST_EMIT, "empty serve did not report")
  `LPS_ASSERT(a_add_count, clk, rst, add_ok |=> count == $past(count) + CNT_W'(1), "add did not grow table")
  `LPS_ASSERT(a_wr_in_table, clk, rst, ram_we && (state != ST_IDLE) |-> CNT_W'(ram_waddr) < count, "write outside live entries")

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for linear_priority_scheduler: predicts each response word
// from its own copy of the entry table and compares field by field as words arrive.
// Depends on lps_pkg and the lps_cmd_if / lps_rsp_if interfaces from the RTL.
`timescale 1ns / 1ps

module testbench;
  import lps_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   served_id;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  remaining;
  } outcome_t;

  class outcome_board;
    logic [ID_W-1:0]   ids[$];
    logic [PRIO_W-1:0] prios[$];
    outcome_t          expected[$];
    int                errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void note_word(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
                            logic [PRIO_W-1:0] p);
      outcome_t o;
      int best;
      o = '0;
      case (m)
        MODE_ADD: begin
          if (ids.size() >= DEPTH_DEF) begin
            o.status    = STAT_FULL;
            o.remaining = POS_W'(ids.size());
            expected.push_back(o);
          end else begin
            ids.push_back(id);
            prios.push_back(p);
          end
        end
        MODE_UPDATE: begin
          for (int i = 0; i < ids.size(); i++) begin
            if (ids[i] == id) begin
              prios[i] = p;
              break;
            end
          end
        end
        MODE_SERVE: begin
          if (ids.size() == 0) begin
            o.status = STAT_EMPTY;
          end else begin
            best = 0;
            for (int i = 1; i < ids.size(); i++) begin
              if (prios[i] > prios[best] || (prios[i] == prios[best] && ids[i] < ids[best]))
                best = i;
            end
            o.status    = STAT_SERVED;
            o.served_id = ids[best];
            o.position  = POS_W'(best + 1);
            ids.delete(best);
            prios.delete(best);
            o.remaining = POS_W'(ids.size());
          end
          expected.push_back(o);
        end
        default: ;
      endcase
    endfunction

    task check_word(outcome_t got);
      outcome_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected response status=%0d id=%0h pos=%0d rem=%0d",
                         got.status, got.served_id, got.position, got.remaining));
      end else begin
        want = expected.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.served_id !== want.served_id)
          report($sformatf("served_id %0h, expected %0h", got.served_id, want.served_id));
        if (got.position !== want.position)
          report($sformatf("position %0d, expected %0d", got.position, want.position));
        if (got.remaining !== want.remaining)
          report($sformatf("remaining %0d, expected %0d", got.remaining, want.remaining));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  int   words_sent;
  int   stall_left;

  outcome_board board;

  lps_cmd_if cmd ();
  lps_rsp_if rsp ();

  linear_priority_scheduler dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("** linear_priority_scheduler: FAILED **");
    $finish;
  end

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (board.ids.size() != 0 && r < 55)
      return board.ids[$urandom_range(0, board.ids.size() - 1)];
    if (r < 80)
      return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return PRIO_W'($urandom_range(0, 7));
    if (r < 55)
      return '0;
    if (r < 65)
      return '1;
    return PRIO_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] p);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid        <= 1'b1;
    cmd.mode         <= m;
    cmd.task_id      <= id;
    cmd.priority_req <= p;
    do @(posedge clk); while (!cmd.ready);
    board.note_word(m, id, p);
    if (m != MODE_UNUSED)
      words_sent++;
  endtask

  task automatic wait_for_outcomes();
    cmd.valid <= 1'b0;
    while (board.expected.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int add_pct, input int upd_pct,
                              input int srv_pct);
    int r;
    logic [MODE_W-1:0] m;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct)
        m = MODE_ADD;
      else if (r < add_pct + upd_pct)
        m = MODE_UPDATE;
      else if (r < add_pct + upd_pct + srv_pct)
        m = MODE_SERVE;
      else
        m = MODE_UNUSED;
      send_word(m, pick_id(), pick_prio());
    end
  endtask

  // response side: check on handshake, stall in bursts
  initial begin
    rsp.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready)
        board.check_word('{rsp.status, rsp.served_id, rsp.position, rsp.remaining});
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 4);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    board      = new();
    idle_on    = 1'b1;
    words_sent = 0;
    rst              <= 1'b1;
    cmd.valid        <= 1'b0;
    cmd.mode         <= MODE_ADD;
    cmd.task_id      <= '0;
    cmd.priority_req <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(MODE_SERVE, '0, '0);
    send_word(MODE_ADD, 16'hFFFF, 16'h0000);
    send_word(MODE_ADD, 16'h0000, 16'hFFFF);
    send_word(MODE_ADD, 16'h1234, 16'h0007);
    send_word(MODE_ADD, 16'h0005, 16'h0007);
    send_word(MODE_ADD, 16'h0005, 16'h0007);
    send_word(MODE_UPDATE, 16'h1234, 16'hFFFF);
    send_word(MODE_UPDATE, 16'hBEEF, 16'h0001);
    send_word(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
    send_word(MODE_SERVE, '1, '1);
    send_word(MODE_SERVE, '0, '0);
    send_word(MODE_SERVE, '0, '0);
    send_word(MODE_SERVE, '0, '0);
    send_word(MODE_UPDATE, 16'hFFFF, 16'hAAAA);
    send_word(MODE_SERVE, '0, '0);
    send_word(MODE_SERVE, '0, '0);
    send_word(MODE_ADD, 16'hA5A5, 16'h5A5A);
    send_word(MODE_ADD, 16'h5A5A, 16'hA5A5);
    send_word(MODE_UPDATE, 16'h5A5A, 16'h5A5A);
    send_word(MODE_SERVE, '0, '0);
    send_word(MODE_SERVE, '0, '0);
    wait_for_outcomes();

    while (words_sent < 1100) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: random_phase($urandom_range(60, 160), 80, 8, 10);
        1: random_phase($urandom_range(40, 140), 15, 10, 73);
        default: random_phase($urandom_range(40, 140), 45, 15, 38);
      endcase
      if ($urandom_range(0, 4) == 0)
        wait_for_outcomes();
    end

    idle_on = 1'b0;
    random_phase(150, 45, 15, 38);
    wait_for_outcomes();
    repeat (300) @(posedge clk);

    if (board.errors == 0 && board.expected.size() == 0) begin
      $display("** linear_priority_scheduler: PASSED **");
    end else begin
      $display("** linear_priority_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/lps_ram.sv
rtl/lps_cmp.sv
rtl/linear_priority_scheduler.sv
verif/testbench.sv
